FILE: design/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define CHK_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// Checks that a consequent follows an antecedent at the same edge.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

FILE: design/dlphb_pkg.sv
// Package with types, codes and the glyph table of the drum printer hammer buffer.
`default_nettype none
package dlphb_pkg;

	localparam int CHAR_W = 7;
	localparam int FILL_W = 4;
	localparam int LANES = 16;

	typedef enum logic [1:0] {
		KIND_CTRL   = 2'd0,
		KIND_HAMMER = 2'd1,
		KIND_TICK   = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	localparam logic [3:0] CMD_LINEFEED = 4'd1;
	localparam logic [3:0] CMD_STOP_A   = 4'd2;
	localparam logic [3:0] CMD_START    = 4'd4;
	localparam logic [3:0] CMD_STOP_B   = 4'd8;
	localparam logic [3:0] CMD_STOP_C   = 4'd10;

	localparam logic CFG_ATTACHED = 1'b0;
	localparam logic CFG_LATIN    = 1'b1;

	localparam logic [15:0] SYM_SPACE = 16'h0020;
	localparam logic [15:0] SYM_CR    = 16'h000d;
	localparam logic [15:0] SYM_LF    = 16'h000a;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HAMMER,
		ST_READ,
		ST_FINISH
	} state_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  command;
		logic [2:0]  base_position;
		logic [15:0] hammer_mask;
	} in_t;

	typedef struct packed {
		logic [15:0] symbol;
		logic        symbol_valid;
		logic        last_of_line;
		logic        sync_pulse;
		logic        zero_pulse;
		logic        linefeed_ready;
		logic        strike_dropped;
	} out_t;

	typedef struct packed {
		logic       go;
		logic       clr;
		logic       drum_nz;
		logic [2:0] base;
		logic [2:0] rd_sel;
	} lane_ctl_t;

	function automatic logic [15:0] glyph_of(logic [CHAR_W-1:0] code, logic latin);
		logic [15:0] g;
		g = SYM_SPACE;
		case (code)
			7'd1: g = 16'h0030;  7'd2: g = 16'h0031;  7'd3: g = 16'h0032;  7'd4: g = 16'h0033;
			7'd5: g = 16'h0034;  7'd6: g = 16'h0035;  7'd7: g = 16'h0036;  7'd8: g = 16'h0037;
			7'd9: g = 16'h0038;  7'd10: g = 16'h0039; 7'd11: g = 16'h002b; 7'd12: g = 16'h002d;
			7'd13: g = 16'h002f; 7'd14: g = 16'h002c; 7'd15: g = 16'h002e; 7'd16: g = 16'h2423;
			7'd17: g = 16'h0065; 7'd18: g = 16'h2191; 7'd19: g = 16'h0028; 7'd20: g = 16'h0029;
			7'd21: g = 16'h00d7; 7'd22: g = 16'h003d; 7'd23: g = 16'h003b; 7'd24: g = 16'h005b;
			7'd25: g = 16'h005d; 7'd26: g = 16'h002a; 7'd27: g = 16'h2018; 7'd28: g = 16'h2019;
			7'd29: g = 16'h2260; 7'd30: g = 16'h003c; 7'd31: g = 16'h003e; 7'd32: g = 16'h003a;
			7'd33: g = 16'h0410; 7'd34: g = 16'h0411; 7'd35: g = 16'h0412; 7'd36: g = 16'h0413;
			7'd37: g = 16'h0414; 7'd38: g = 16'h0415; 7'd39: g = 16'h0416; 7'd40: g = 16'h0417;
			7'd41: g = 16'h0418; 7'd42: g = 16'h0419; 7'd43: g = 16'h041a; 7'd44: g = 16'h041b;
			7'd45: g = 16'h041c; 7'd46: g = 16'h041d; 7'd47: g = 16'h041e; 7'd48: g = 16'h041f;
			7'd49: g = 16'h0420; 7'd50: g = 16'h0421; 7'd51: g = 16'h0422; 7'd52: g = 16'h0423;
			7'd53: g = 16'h0424; 7'd54: g = 16'h0425; 7'd55: g = 16'h0426; 7'd56: g = 16'h0427;
			7'd57: g = 16'h0428; 7'd58: g = 16'h0429; 7'd59: g = 16'h042b; 7'd60: g = 16'h042c;
			7'd61: g = 16'h042d; 7'd62: g = 16'h042e; 7'd63: g = 16'h042f; 7'd64: g = 16'h0044;
			7'd65: g = 16'h0046; 7'd66: g = 16'h0047; 7'd67: g = 16'h0049; 7'd68: g = 16'h004a;
			7'd69: g = 16'h004c; 7'd70: g = 16'h004e; 7'd71: g = 16'h0051; 7'd72: g = 16'h0052;
			7'd73: g = 16'h0053; 7'd74: g = 16'h0055; 7'd75: g = 16'h0056; 7'd76: g = 16'h0057;
			7'd77: g = 16'h005a; 7'd78: g = 16'h203e; 7'd79: g = 16'h2264; 7'd80: g = 16'h2265;
			7'd81: g = 16'h2228; 7'd82: g = 16'h2227; 7'd83: g = 16'h2283; 7'd84: g = 16'h00ac;
			7'd85: g = 16'h00f7; 7'd86: g = 16'h2261; 7'd87: g = 16'h0025; 7'd88: g = 16'h25c7;
			7'd89: g = 16'h007c; 7'd90: g = 16'h2015; 7'd91: g = 16'h005f; 7'd92: g = 16'h0021;
			7'd93: g = 16'h0022; 7'd94: g = 16'h042a; 7'd95: g = 16'h00b0; 7'd96: g = 16'h2032;
			default: g = SYM_SPACE;
		endcase
		if (latin) begin
			case (code)
				7'd33: g = 16'h0041; 7'd35: g = 16'h0042; 7'd38: g = 16'h0045;
				7'd43: g = 16'h004b; 7'd45: g = 16'h004d; 7'd46: g = 16'h0048;
				7'd47: g = 16'h004f; 7'd49: g = 16'h0050; 7'd50: g = 16'h0043;
				7'd51: g = 16'h0054; 7'd52: g = 16'h0059; 7'd54: g = 16'h0058;
				default: g = g;
			endcase
		end
		return g;
	endfunction

endpackage
`default_nettype wire

FILE: design/dlphb_lane.sv
// One hammer lane: the overprint fill counts of eight columns and their slot lookup.
`default_nettype none
module dlphb_lane #(
	parameter int LANE = 0,
	parameter int COLS = 128,
	parameter int MAX_OVERPRINT = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dlphb_pkg::lane_ctl_t         ctl,
	input  logic                         fire,
	output logic                         strike,
	output logic [dlphb_pkg::FILL_W-1:0] slot,
	output logic [dlphb_pkg::FILL_W-1:0] rd_fill
);
	import dlphb_pkg::*;

	logic [FILL_W-1:0] fill_q [8];
	logic              col_ok;

	assign col_ok  = (int'(ctl.base) + LANE * 8) < COLS;
	assign slot    = fill_q[ctl.base];
	assign strike  = fire && col_ok && (slot < FILL_W'(MAX_OVERPRINT));
	assign rd_fill = fill_q[ctl.rd_sel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < 8; b++) fill_q[b] <= '0;
		end else if (ctl.clr) begin
			for (int b = 0; b < 8; b++) fill_q[b] <= '0;
		end else if (ctl.go && strike && ctl.drum_nz) begin
			fill_q[ctl.base] <= slot + FILL_W'(1);
		end
	end

endmodule
`default_nettype wire

FILE: design/drum_line_printer_hammer_buffer.sv
// Top level of the drum line printer hammer buffer: control, merge sequencer and line memory.
`default_nettype none
// One request at a time. Control commands, drum ticks, reads that give CR, LF or nothing and
// hammer requests dropped during a pending drain go from acceptance through the finish state
// to the output register; a read of a line cell goes through a read state first because the
// line memory has one registered read port; a hammer request walks the hammer state, where
// the merge sequencer visits the 16 lanes and writes one strike a cycle through the single
// memory write port. A finished result waits while the output register holds one that is
// not yet taken, and no new request is taken meanwhile.
// Overprint fill counts live in flip-flops per column, so reset and end of line clear the
// line at once and no clearing pass is needed.
module drum_line_printer_hammer_buffer #(
	parameter int LINE_COLUMNS  = 128,
	parameter int MAX_OVERPRINT = 10,
	parameter int DRUM_SYMBOLS  = 96,
	parameter int FEED_TICKS    = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  dlphb_pkg::in_t  in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output dlphb_pkg::out_t out_data,
	input  logic            cfg_we,
	input  logic [0:0]      cfg_index,
	input  logic [0:0]      cfg_data
);
	import dlphb_pkg::*;

	`include "assert_macros.svh"

	localparam int COLS  = (LINE_COLUMNS < 128) ? LINE_COLUMNS : 128;
	localparam int DEPTH = COLS * MAX_OVERPRINT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	state_t state_q, state_d;

	logic attached_q, latin_q;
	logic [CHAR_W-1:0] drum_char_q;
	logic [1:0] feed_count_q;
	logic motor_on_q, feed_done_q;
	logic [7:0] used_length_q;
	logic [3:0] used_passes_q;
	logic drain_pending_q;
	logic [3:0] drain_pass_q;
	logic [7:0] drain_column_q;
	logic [1:0] drain_phase_q;

	logic [LANES-1:0] strike_s1;
	logic [FILL_W-1:0] slot_s1 [LANES];
	logic [2:0] base_s1;
	logic [3:0] k_q;

	out_t res_q, res_d, out_d;
	logic use_cell_q, cell_ok_q;
	logic [AW-1:0] rd_addr_q;
	logic [CHAR_W-1:0] mem_rd_q;
	logic [CHAR_W-1:0] mem [DEPTH];
	out_t out_q;
	logic out_valid_q;

	lane_ctl_t ctl;
	logic [LANES-1:0] lane_strike;
	logic [FILL_W-1:0] lane_slot [LANES];
	logic [FILL_W-1:0] lane_fill [LANES];

	logic acc, drain_end, mem_we, fin_go, cell_rd;
	logic [6:0] wr_col;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [FILL_W-1:0] fill_sel;
	logic [7:0] col_nx;
	logic [3:0] pass_nx;

	assign acc       = in_valid && !in_stall;
	assign drain_end = (drain_pass_q >= used_passes_q) || (used_length_q == 8'd0);
	assign cell_rd   = (in_data.kind == KIND_READ) && drain_pending_q && !drain_end
			&& (drain_phase_q != 2'd1);
	assign wr_col    = {k_q, base_s1};
	assign wr_addr   = AW'(int'(wr_col) * MAX_OVERPRINT + int'(slot_s1[k_q]));
	assign rd_addr   = AW'(int'(drain_column_q[6:0]) * MAX_OVERPRINT + int'(drain_pass_q));
	assign fill_sel  = lane_fill[drain_column_q[6:3]];
	assign col_nx    = drain_column_q + 8'd1;
	assign pass_nx   = drain_pass_q + 4'd1;

	assign ctl.go      = acc && (in_data.kind == KIND_HAMMER) && !drain_pending_q;
	assign ctl.clr     = acc && (in_data.kind == KIND_READ) && drain_pending_q && drain_end;
	assign ctl.drum_nz = drum_char_q != '0;
	assign ctl.base    = in_data.base_position;
	assign ctl.rd_sel  = drain_column_q[2:0];

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		dlphb_lane #(
			.LANE(i),
			.COLS(COLS),
			.MAX_OVERPRINT(MAX_OVERPRINT)
		) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.fire(in_data.hammer_mask[i]),
			.strike(lane_strike[i]),
			.slot(lane_slot[i]),
			.rd_fill(lane_fill[i])
		);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (in_data.kind == KIND_HAMMER && !drain_pending_q) begin
						state_d = ST_HAMMER;
					end else if (cell_rd) begin
						state_d = ST_READ;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_HAMMER: if (k_q == 4'd15) state_d = ST_FINISH;
			ST_READ: state_d = ST_FINISH;
			ST_FINISH: if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = state_q != ST_IDLE;
		mem_we   = (state_q == ST_HAMMER) && strike_s1[k_q] && (drum_char_q != '0);
		fin_go   = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);
	end

	always_comb begin
		res_d = '0;
		unique case (in_data.kind)
			KIND_CTRL: ;
			KIND_HAMMER: res_d.strike_dropped = drain_pending_q;
			KIND_TICK: begin
				if (motor_on_q) begin
					if (drum_char_q < CHAR_W'(DRUM_SYMBOLS)) res_d.sync_pulse = 1'b1;
					else res_d.zero_pulse = 1'b1;
				end
			end
			KIND_READ: begin
				if (drain_pending_q) begin
					res_d.symbol_valid = 1'b1;
					if (drain_end) begin
						res_d.symbol = SYM_LF;
						res_d.last_of_line = 1'b1;
					end else if (drain_phase_q == 2'd1) begin
						res_d.symbol = SYM_CR;
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		out_d = res_q;
		out_d.linefeed_ready = feed_done_q;
		if (use_cell_q) begin
			out_d.symbol = cell_ok_q ? glyph_of(mem_rd_q, latin_q) : SYM_SPACE;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= drum_char_q;
		mem_rd_q <= mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			attached_q <= 1'b0;
			latin_q <= 1'b0;
			drum_char_q <= '0;
			feed_count_q <= '0;
			motor_on_q <= 1'b0;
			feed_done_q <= 1'b0;
			used_length_q <= '0;
			used_passes_q <= '0;
			drain_pending_q <= 1'b0;
			drain_pass_q <= '0;
			drain_column_q <= '0;
			drain_phase_q <= '0;
			strike_s1 <= '0;
			for (int i = 0; i < LANES; i++) slot_s1[i] <= '0;
			base_s1 <= '0;
			k_q <= '0;
			res_q <= '0;
			use_cell_q <= 1'b0;
			cell_ok_q <= 1'b0;
			rd_addr_q <= '0;
			out_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ATTACHED: attached_q <= cfg_data[0];
					CFG_LATIN:    latin_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (acc) begin
				res_q <= res_d;
				use_cell_q <= cell_rd;
				k_q <= '0;
				unique case (in_data.kind)
					KIND_CTRL: begin
						if (attached_q) begin
							if (in_data.command == CMD_LINEFEED) begin
								feed_done_q <= 1'b0;
								feed_count_q <= 2'(FEED_TICKS);
								if (!drain_pending_q) begin
									drain_pending_q <= 1'b1;
									drain_pass_q <= '0;
									drain_column_q <= '0;
									drain_phase_q <= '0;
								end
							end else if (in_data.command == CMD_START) begin
								feed_done_q <= 1'b0;
								feed_count_q <= 2'(FEED_TICKS);
								motor_on_q <= 1'b1;
							end else if (in_data.command == CMD_STOP_A
									|| in_data.command == CMD_STOP_B
									|| in_data.command == CMD_STOP_C) begin
								motor_on_q <= 1'b0;
							end
						end
					end
					KIND_HAMMER: begin
						if (!drain_pending_q) begin
							strike_s1 <= lane_strike;
							for (int i = 0; i < LANES; i++) slot_s1[i] <= lane_slot[i];
							base_s1 <= in_data.base_position;
						end
					end
					KIND_TICK: begin
						if (motor_on_q) begin
							if (drum_char_q < CHAR_W'(DRUM_SYMBOLS)) begin
								drum_char_q <= drum_char_q + CHAR_W'(1);
								if (feed_count_q != 2'd0) begin
									feed_count_q <= feed_count_q - 2'd1;
									if (feed_count_q == 2'd1) feed_done_q <= 1'b1;
								end
							end else begin
								drum_char_q <= '0;
							end
						end
					end
					KIND_READ: begin
						if (drain_pending_q) begin
							if (drain_end) begin
								used_length_q <= '0;
								used_passes_q <= '0;
								drain_pending_q <= 1'b0;
								drain_pass_q <= '0;
								drain_column_q <= '0;
								drain_phase_q <= '0;
							end else if (drain_phase_q == 2'd1) begin
								drain_phase_q <= '0;
							end else begin
								cell_ok_q <= drain_pass_q < fill_sel;
								rd_addr_q <= rd_addr;
								if (col_nx >= used_length_q) begin
									drain_column_q <= '0;
									drain_pass_q <= pass_nx;
									if (pass_nx < used_passes_q) drain_phase_q <= 2'd1;
								end else begin
									drain_column_q <= col_nx;
								end
							end
						end
					end
					default: ;
				endcase
			end
			if (state_q == ST_HAMMER) begin
				k_q <= k_q + 4'd1;
				if (strike_s1[k_q]) begin
					if ({1'b0, wr_col} + 8'd1 > used_length_q) begin
						used_length_q <= {1'b0, wr_col} + 8'd1;
					end
					if (slot_s1[k_q] + 4'd1 > used_passes_q) begin
						used_passes_q <= slot_s1[k_q] + 4'd1;
					end
				end
			end
			if (fin_go) begin
				out_q <= out_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`CHK_ALWAYS(a_passes_bound, clk, arst_n, used_passes_q <= 4'(MAX_OVERPRINT))
	`CHK_ALWAYS(a_len_pass_pair, clk, arst_n, (used_length_q == 8'd0) == (used_passes_q == 4'd0))
	`CHK_IMPLY(a_drain_pass, clk, arst_n, drain_pending_q, drain_pass_q <= used_passes_q)

endmodule
`default_nettype wire
